// ===== hdl/per_key_top_k_neighbor_table_assert.svh =====
// assertion macros for the neighbor table checker
// no dependencies
`ifndef PER_KEY_TOP_K_NEIGHBOR_TABLE_ASSERT_SVH
`define PER_KEY_TOP_K_NEIGHBOR_TABLE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PKT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication whose consequent is checked in the following cycle
`define PKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hdl/pktn_pkg.sv =====
// shared types and constants of the neighbor table
// no dependencies
`default_nettype none
package pktn_pkg;
    localparam int ITEM_COUNT_DEF    = 1024;
    localparam int MAX_NEIGHBORS_DEF = 32;
    localparam int ID_W    = 10;
    localparam int SCORE_W = 16;
    localparam int CNT_W   = 6;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 16'sh7FFF;
    localparam logic [CNT_W-1:0] SLOT_INVALID = 6'd63;

    localparam logic [2:0] ST_FREE      = 3'd0;
    localparam logic [2:0] ST_REPLACED  = 3'd1;
    localparam logic [2:0] ST_REJECTED  = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_NONE      = 3'd4;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [1:0] REG_SYM  = 2'd0;
    localparam logic [1:0] REG_DUP  = 2'd1;
    localparam logic [1:0] REG_KUSE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_HREAD, S_HWAIT, S_DECIDE, S_SREAD, S_SCAN,
        S_ADD, S_REPL, S_RREAD, S_RSCAN, S_WRHDR, S_DONE
    } state_t;

    // per-item header: count, lowest slot, lowest score
    typedef struct packed {
        logic [CNT_W-1:0]          count;
        logic [CNT_W-1:0]          slot;
        logic signed [SCORE_W-1:0] score;
    } hdr_t;

    typedef struct packed {
        logic             sym;
        logic             dup;
        logic [CNT_W-1:0] kuse;
    } cfg_t;
endpackage
`default_nettype wire

// ===== hdl/per_key_top_k_neighbor_table.sv =====
// top level of the per-item top-k neighbor table
// depends on pktn_pkg, pktn_cfg, pktn_ctrl
//
// usage: pulse start with command, cell_a, cell_b, similarity while busy
// is low. the command is taken at that edge; busy stays high until the
// result word is shown. done is high for exactly one cycle with status_a,
// status_b and found valid; the receiver cannot stall it.
// an add is worked on one list at a time (cell_a, then cell_b in
// symmetric mode). per list: header read, a duplicate scan of the stored
// slots when enabled, slot write, for a replace a minimum rescan of the
// slots, then header write. a query reads the header and scans the slots.
// the slot scans read one slot at a time through the single port of the
// slot memory. after reset the header memory is cleared one item per
// cycle with busy high; apb writes are taken during it. the user must
// write configuration over apb only while busy is low; the block itself
// does not enforce this.
`default_nettype none
module per_key_top_k_neighbor_table #(
    parameter int ITEM_COUNT    = pktn_pkg::ITEM_COUNT_DEF,
    parameter int MAX_NEIGHBORS = pktn_pkg::MAX_NEIGHBORS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [pktn_pkg::ID_W-1:0] cell_a,
    input  wire logic [pktn_pkg::ID_W-1:0] cell_b,
    input  wire logic signed [pktn_pkg::SCORE_W-1:0] similarity,
    output logic             done,
    output logic [2:0]       status_a,
    output logic [2:0]       status_b,
    output logic             found
);
    import pktn_pkg::*;
    cfg_t cfg;

    pktn_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .cfg(cfg));

    pktn_ctrl #(.ITEM_COUNT(ITEM_COUNT), .MAX_NEIGHBORS(MAX_NEIGHBORS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .start(start), .command(command),
        .cell_a(cell_a), .cell_b(cell_b), .similarity(similarity),
        .busy(busy), .done(done), .status_a(status_a), .status_b(status_b),
        .found(found));
endmodule
`default_nettype wire

// ===== hdl/pktn_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
`default_nettype none
module pktn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== hdl/pktn_cfg.sv =====
// apb configuration registers of the neighbor table
// depends on pktn_pkg
`default_nettype none
module pktn_cfg (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output pktn_pkg::cfg_t   cfg
);
    import pktn_pkg::*;
    cfg_t cfg_reg;
    logic [1:0] idx;

    assign idx    = paddr[3:2];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sym: 1'b1, dup: 1'b1, kuse: 6'd32};
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_SYM:  cfg_reg.sym  <= pwdata[0];
                REG_DUP:  cfg_reg.dup  <= pwdata[0];
                REG_KUSE: cfg_reg.kuse <= pwdata[CNT_W-1:0];
                default:  ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_SYM:  prdata = {31'd0, cfg_reg.sym};
            REG_DUP:  prdata = {31'd0, cfg_reg.dup};
            REG_KUSE: prdata = {26'd0, cfg_reg.kuse};
            default:  prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// ===== hdl/pktn_ctrl.sv =====
// sequencer: header and slot memories, scans, insert and replace
// depends on pktn_pkg and pktn_ram
`default_nettype none
module pktn_ctrl #(
    parameter int ITEM_COUNT    = pktn_pkg::ITEM_COUNT_DEF,
    parameter int MAX_NEIGHBORS = pktn_pkg::MAX_NEIGHBORS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  pktn_pkg::cfg_t                   cfg,
    input  wire logic                        start,
    input  wire logic                        command,
    input  wire logic [pktn_pkg::ID_W-1:0]   cell_a,
    input  wire logic [pktn_pkg::ID_W-1:0]   cell_b,
    input  wire logic signed [pktn_pkg::SCORE_W-1:0] similarity,
    output logic                             busy,
    output logic                             done,
    output logic [2:0]                       status_a,
    output logic [2:0]                       status_b,
    output logic                             found
);
    import pktn_pkg::*;
    localparam int IW  = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;
    localparam int SW  = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
    localparam int DW  = ID_W + SCORE_W;
    localparam int HW  = $bits(hdr_t);
    localparam int KW  = $clog2(MAX_NEIGHBORS + 1);
    localparam int FIW = (ITEM_COUNT > (1 << ID_W)) ? IW + 1 : ID_W + 1;

    state_t state_reg, state_next;
    logic   cmd_reg;
    logic [ID_W-1:0] a_reg, b_reg, item_reg, id_reg;
    logic signed [SCORE_W-1:0] sc_reg;
    logic   side_reg, side_next;          // 0 list of cell_a, 1 list of cell_b
    hdr_t   hdr_reg, hdr_next;
    logic [KW-1:0] idx_reg, idx_next;
    logic   hit_reg, hit_next;
    logic [2:0] sa_reg, sa_next, sb_reg, sb_next;
    logic   fnd_reg, fnd_next;
    logic [IW-1:0] clr_reg, clr_next;

    // memory ports
    logic          h_we, s_we;
    logic [IW-1:0] h_addr;
    hdr_t          h_wdata, h_rdata;
    logic [IW+SW-1:0] s_addr;
    logic [DW-1:0] s_wdata, s_rdata;
    logic [ID_W-1:0] rd_id;
    logic signed [SCORE_W-1:0] rd_sc;

    pktn_ram #(.WIDTH(HW), .DEPTH(1 << IW)) u_hdr_ram (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));
    pktn_ram #(.WIDTH(DW), .DEPTH(1 << (IW + SW))) u_slot_ram (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));

    assign rd_id = s_rdata[DW-1:SCORE_W];
    assign rd_sc = s_rdata[SCORE_W-1:0];

    // effective k and scan limit
    logic [KW-1:0] k_eff, n_lim, cnt_k;
    logic          in_range, full, more;
    logic [FIW-1:0] item_ext;
    always_comb
    begin
        if (cfg.kuse == '0)
            k_eff = KW'(1);
        else if (32'(cfg.kuse) > MAX_NEIGHBORS)
            k_eff = KW'(MAX_NEIGHBORS);
        else
            k_eff = KW'(cfg.kuse);
        cnt_k = (32'(hdr_reg.count) > MAX_NEIGHBORS) ? KW'(MAX_NEIGHBORS)
                                                     : KW'(hdr_reg.count);
        n_lim = cnt_k;
        full  = (32'(hdr_reg.count) >= 32'(k_eff));
        item_ext = FIW'(item_reg);
        in_range = (32'(item_ext) < ITEM_COUNT);
        more  = (idx_reg < n_lim);
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_DONE);
    assign status_a = sa_reg;
    assign status_b = sb_reg;
    assign found    = fnd_reg;

    // state and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= command;
            a_reg   <= cell_a;
            b_reg   <= cell_b;
            sc_reg  <= similarity;
        end
        side_reg <= side_next;
        hdr_reg  <= hdr_next;
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        sa_reg   <= sa_next;
        sb_reg   <= sb_next;
        fnd_reg  <= fnd_next;
    end

    assign item_reg = side_reg ? b_reg : a_reg;
    assign id_reg   = side_reg ? a_reg : b_reg;

    // sequencer
    logic [2:0] res;
    logic       res_v;
    always_comb
    begin
        state_next = state_reg;
        side_next  = side_reg;
        hdr_next   = hdr_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        fnd_next   = fnd_reg;
        clr_next   = clr_reg;
        h_we    = 1'b0;
        h_addr  = IW'(item_reg);
        h_wdata = hdr_reg;
        s_we    = 1'b0;
        s_addr  = {IW'(item_reg), SW'(idx_reg)};
        s_wdata = {id_reg, sc_reg};
        res     = ST_NONE;
        res_v   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                h_we    = 1'b1;
                h_addr  = clr_reg;
                h_wdata = '{count: '0, slot: SLOT_INVALID, score: SCORE_MAX};
                clr_next = clr_reg + IW'(1);
                if (clr_reg == IW'((1 << IW) - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                side_next = 1'b0;
                sa_next   = ST_NONE;
                sb_next   = ST_NONE;
                fnd_next  = 1'b0;
                if (start)
                    state_next = S_HREAD;
            end
            S_HREAD:
            begin
                if (!in_range)
                begin
                    res   = (cmd_reg == CMD_QUERY) ? ST_NONE : ST_REJECTED;
                    res_v = 1'b1;
                end
                else
                    state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                hdr_next   = h_rdata;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                idx_next = '0;
                hit_next = 1'b0;
                if (cmd_reg == CMD_QUERY)
                    state_next = S_SREAD;
                else if (full && sc_reg <= hdr_reg.score)
                begin
                    res = ST_REJECTED; res_v = 1'b1;
                end
                else if (cfg.dup)
                    state_next = S_SREAD;
                else
                    state_next = full ? S_REPL : S_ADD;
            end
            // duplicate or query scan: each slot is read in S_SREAD and compared in S_SCAN
            S_SREAD:
            begin
                if (!more)
                begin
                    if (cmd_reg == CMD_QUERY)
                    begin
                        res = ST_NONE; res_v = 1'b1;
                    end
                    else
                        state_next = full ? S_REPL : S_ADD;
                end
                else
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                idx_next = idx_reg + KW'(1);
                if (rd_id == id_reg)
                begin
                    if (cmd_reg == CMD_QUERY)
                        fnd_next = 1'b1;
                    res = ST_DUPLICATE; res_v = (cmd_reg != CMD_QUERY);
                    if (cmd_reg == CMD_QUERY)
                    begin
                        res = ST_NONE; res_v = 1'b1;
                    end
                end
                else
                    state_next = S_SREAD;
            end
            S_ADD:
            begin
                s_we   = 1'b1;
                s_addr = {IW'(item_reg), SW'(hdr_reg.count)};
                if (sc_reg < hdr_reg.score)
                begin
                    hdr_next.slot  = hdr_reg.count;
                    hdr_next.score = sc_reg;
                end
                hdr_next.count = hdr_reg.count + CNT_W'(1);
                state_next = S_WRHDR;
                hit_next   = 1'b0;
            end
            S_REPL:
            begin
                if (32'(hdr_reg.slot) >= 32'(hdr_reg.count)
                    || 32'(hdr_reg.slot) >= MAX_NEIGHBORS)
                begin
                    res = ST_REJECTED; res_v = 1'b1;
                end
                else
                begin
                    s_we   = 1'b1;
                    s_addr = {IW'(item_reg), SW'(hdr_reg.slot)};
                    hdr_next.slot  = SLOT_INVALID;
                    hdr_next.score = SCORE_MAX;
                    idx_next = '0;
                    hit_next = 1'b1;
                    state_next = S_RREAD;
                end
            end
            // minimum rescan
            S_RREAD:
            begin
                if (!more)
                    state_next = S_WRHDR;
                else
                    state_next = S_RSCAN;
            end
            S_RSCAN:
            begin
                idx_next = idx_reg + KW'(1);
                if (rd_sc < hdr_reg.score)
                begin
                    hdr_next.slot  = CNT_W'(idx_reg);
                    hdr_next.score = rd_sc;
                end
                state_next = S_RREAD;
            end
            S_WRHDR:
            begin
                h_we  = 1'b1;
                res   = hit_reg ? ST_REPLACED : ST_FREE;
                res_v = 1'b1;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        // finish one list: record status, go on to the reverse pair or report
        if (res_v)
        begin
            if (side_reg)
                sb_next = res;
            else
                sa_next = res;
            if (!side_reg && cmd_reg == CMD_ADD && cfg.sym)
            begin
                side_next  = 1'b1;
                state_next = S_HREAD;
            end
            else
                state_next = S_DONE;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/pktn_checker.sv =====
// port-level checker of the neighbor table, bound to the top level
// depends on pktn_pkg and the assertion macro header
`default_nettype none
`include "per_key_top_k_neighbor_table_assert.svh"
module pktn_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic       pready,
    input wire logic [2:0] status_a,
    input wire logic [2:0] status_b,
    input wire logic       found
);
    import pktn_pkg::*;
    `PKT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
    `PKT_ASSERT_NEXT(a_done_idle, done, !busy, "busy held after result word")
    `PKT_ASSERT_IMP(a_found_query, done && found, status_a == ST_NONE && status_b == ST_NONE, "found on an add")
    `PKT_ASSERT_IMP(a_done_busy, done, busy, "result word while idle")
    `PKT_ASSERT_IMP(a_pready, 1'b1, pready, "pready low")
endmodule

bind per_key_top_k_neighbor_table pktn_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .pready(pready), .status_a(status_a), .status_b(status_b), .found(found));
`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the per-item top-k neighbor table: directed and random add/query words
// depends on pktn_pkg and per_key_top_k_neighbor_table; predicts every result word
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pktn_pkg::*;

    localparam int NITEMS = 1024;
    localparam int MAXK   = 32;

    typedef struct packed {
        logic                      cmd;
        logic [ID_W-1:0]           a;
        logic [ID_W-1:0]           b;
        logic signed [SCORE_W-1:0] sim;
    } word_t;

    typedef struct packed {
        logic [2:0] sa;
        logic [2:0] sb;
        logic       fnd;
    } res_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic start, busy, command, done, found;
    logic [ID_W-1:0] cell_a, cell_b;
    logic signed [SCORE_W-1:0] similarity;
    logic [2:0] status_a, status_b;

    per_key_top_k_neighbor_table u_dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy), .command(command), .cell_a(cell_a),
        .cell_b(cell_b), .similarity(similarity), .done(done),
        .status_a(status_a), .status_b(status_b), .found(found)
    );

    // predicted table state
    logic                      sym_mode, dup_chk;
    logic [CNT_W-1:0]          k_reg;
    int                        fill [NITEMS];
    int                        low_score [NITEMS];
    int                        low_slot [NITEMS];
    int                        nb_id [NITEMS][MAXK];
    int                        nb_score [NITEMS][MAXK];

    word_t pending_words[$];
    res_t  expected_results[$];
    int    errors = 0;
    bit    quiet = 0;

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("tb_top NOT OK");
        $finish;
    end

    function automatic int eff_k();
        int k;
        k = k_reg;
        if (k < 1) k = 1;
        if (k > MAXK) k = MAXK;
        return k;
    endfunction

    function automatic bit has_id(int item, int id);
        for (int i = 0; i < fill[item] && i < MAXK; i++)
            if (nb_id[item][i] == id) return 1;
        return 0;
    endfunction

    // one list update, returns status
    function automatic logic [2:0] insert_neighbor(int item, int id, int score);
        int n;
        n = fill[item];
        if (item >= NITEMS) return ST_REJECTED;
        if (n < eff_k()) begin
            if (dup_chk && has_id(item, id)) return ST_DUPLICATE;
            if (score < low_score[item]) begin
                low_slot[item] = n;
                low_score[item] = score;
            end
            nb_id[item][n] = id;
            nb_score[item][n] = score;
            fill[item] = n + 1;
            return ST_FREE;
        end
        if (score <= low_score[item]) return ST_REJECTED;
        if (dup_chk && has_id(item, id)) return ST_DUPLICATE;
        if (low_slot[item] >= n || low_slot[item] >= MAXK) return ST_REJECTED;
        nb_id[item][low_slot[item]] = id;
        nb_score[item][low_slot[item]] = score;
        low_slot[item] = 63;
        low_score[item] = 32767;
        for (int i = 0; i < n && i < MAXK; i++)
            if (nb_score[item][i] < low_score[item]) begin
                low_slot[item] = i;
                low_score[item] = nb_score[item][i];
            end
        return ST_REPLACED;
    endfunction

    function automatic res_t predict_word(word_t w);
        res_t r;
        r.sa = ST_NONE;
        r.sb = ST_NONE;
        r.fnd = 0;
        if (w.cmd == CMD_QUERY)
            r.fnd = has_id(w.a, w.b);
        else begin
            r.sa = insert_neighbor(w.a, w.b, w.sim);
            if (sym_mode) r.sb = insert_neighbor(w.b, w.a, w.sim);
        end
        return r;
    endfunction

    // driver: one word per accepted start
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 0;
            command <= 0;
            cell_a <= 0;
            cell_b <= 0;
            similarity <= 0;
        end else if (!(start && busy)) begin
            if (start) expected_results.push_back(predict_word({command, cell_a, cell_b,
                                                                 similarity}));
            if (pending_words.size() > 0 && (quiet || $urandom_range(99) >= 23)) begin
                word_t w;
                w = pending_words.pop_front();
                start <= 1;
                command <= w.cmd;
                cell_a <= w.a;
                cell_b <= w.b;
                similarity <= w.sim;
            end else
                start <= 0;
        end
    end

    // monitor: compare each result word with the oldest prediction
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                res_t e;
                e = expected_results.pop_front();
                if (status_a !== e.sa) begin
                    $error("status_a expected %0d actual %0d", e.sa, status_a);
                    errors++;
                end
                if (status_b !== e.sb) begin
                    $error("status_b expected %0d actual %0d", e.sb, status_b);
                    errors++;
                end
                if (found !== e.fnd) begin
                    $error("found expected %0d actual %0d", e.fnd, found);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, int val);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_SYM:  sym_mode = val[0];
            REG_DUP:  dup_chk = val[0];
            default:  k_reg = val[5:0];
        endcase
    endtask

    // wait until every queued word is taken and answered
    task automatic drain();
        while (pending_words.size() > 0 || start || busy || expected_results.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic word_t rnd_word(int span, int cmd_pct);
        word_t w;
        w.cmd = ($urandom_range(99) < cmd_pct) ? CMD_QUERY : CMD_ADD;
        w.a = ID_W'($urandom_range(span - 1));
        w.b = ID_W'($urandom_range(span - 1));
        w.sim = SCORE_W'($urandom);
        if ($urandom_range(9) == 0) w.a = ID_W'($urandom);
        if ($urandom_range(9) == 0) w.b = ID_W'($urandom);
        return w;
    endfunction

    task automatic random_phase(int count, int span);
        for (int i = 0; i < count; i++) pending_words.push_back(rnd_word(span, 25));
        drain();
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        rst_n = 0;
        sym_mode = 1; dup_chk = 1; k_reg = 32;
        for (int i = 0; i < NITEMS; i++) begin
            fill[i] = 0;
            low_score[i] = 32767;
            low_slot[i] = 63;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1;
        drain();
        // directed: extremes, duplicates, self pair, queries
        pending_words.push_back({CMD_ADD, 10'd0, 10'd1023, 16'sh7FFF});
        pending_words.push_back({CMD_ADD, 10'd0, 10'd1023, 16'sh8000});
        pending_words.push_back({CMD_ADD, 10'd5, 10'd5, 16'sh0000});
        pending_words.push_back({CMD_QUERY, 10'd0, 10'd1023, 16'sh0000});
        pending_words.push_back({CMD_QUERY, 10'd1023, 10'd0, 16'shFFFF});
        pending_words.push_back({CMD_QUERY, 10'd0, 10'd7, 16'sh1234});
        pending_words.push_back({CMD_ADD, 10'd1023, 10'd0, 16'sh7FFF});
        drain();
        reg_write(REG_KUSE, 2);
        reg_write(REG_SYM, 0);
        for (int s = 0; s < 5; s++)
            pending_words.push_back({CMD_ADD, 10'd9, ID_W'(100 + s), SCORE_W'(s * 1000 - 2000)});
        pending_words.push_back({CMD_ADD, 10'd9, 10'd100, 16'sh7FFF});
        pending_words.push_back({CMD_QUERY, 10'd9, 10'd104, 16'sh0});
        pending_words.push_back({CMD_ADD, 10'd9, 10'd200, 16'sh8000});
        drain();
        // random phases across settings
        reg_write(REG_DUP, 0);
        reg_write(REG_KUSE, 1);
        random_phase(250, 16);
        reg_write(REG_SYM, 1);
        reg_write(REG_KUSE, 0);
        random_phase(250, 16);
        reg_write(REG_DUP, 1);
        reg_write(REG_KUSE, 4);
        quiet = 1;
        random_phase(200, 24);
        quiet = 0;
        reg_write(REG_KUSE, 63);
        random_phase(300, 8);
        reg_write(REG_KUSE, 32);
        random_phase(300, 64);
        reg_write(REG_SYM, 0);
        reg_write(REG_KUSE, 3);
        random_phase(435, 1024);
        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+hdl
hdl/pktn_pkg.sv
hdl/pktn_ram.sv
hdl/pktn_cfg.sv
hdl/pktn_ctrl.sv
hdl/per_key_top_k_neighbor_table.sv
hdl/pktn_checker.sv
tb/tb_top.sv
